### hw/rtl/i2c_master_byte_engine_top_assert.svh
// Assertion macros used by the I2C master byte engine RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef I2C_MASTER_BYTE_ENGINE_TOP_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_TOP_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define I2CM_ASSERT_HOLD(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
// Used by the front queue, the bus sequencer and the top level.
package i2cm_pkg;

    localparam int QDepth = 2;
    localparam int QPtrW  = 1;
    localparam int QCntW  = 2;

    localparam logic [2:0] OP_START    = 3'd1;
    localparam logic [2:0] OP_STOP     = 3'd2;
    localparam logic [2:0] OP_WRITE    = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;
    localparam logic [2:0] OP_WAIT_ACK = 3'd5;

    localparam logic [7:0] PHASE_TICKS_RST = 8'd5;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
    localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

    typedef enum logic [0:0] {
        CFG_PHASE_TICKS = 1'b0,
        CFG_ACK_TIMEOUT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_WRITE    = 3'd3,
        CMD_READ     = 3'd4,
        CMD_WAIT_ACK = 3'd5
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       valid;
        t_item      item;
    } t_req;

    typedef struct packed {
        logic [7:0] phase_ticks;
        logic [7:0] ack_timeout;
    } t_cfg;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_oe;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack_error;
    } t_result;

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_ST_A    = 15'b000000000000010,
        S_ST_B    = 15'b000000000000100,
        S_ST_C    = 15'b000000000001000,
        S_SP_A    = 15'b000000000010000,
        S_SP_B    = 15'b000000000100000,
        S_SP_C    = 15'b000000001000000,
        S_WR_LO   = 15'b000000010000000,
        S_WR_HI   = 15'b000000100000000,
        S_RD_LO   = 15'b000001000000000,
        S_RD_HI   = 15'b000010000000000,
        S_AK_LO   = 15'b000100000000000,
        S_AK_HI   = 15'b001000000000000,
        S_WA_LO   = 15'b010000000000000,
        S_WA_POLL = 15'b100000000000000
    } t_state;

endpackage

### hw/rtl/i2c_master_byte_engine_top.sv
// Throughput: one request per clock cycle while the result queue has room,
// set by the one-tick sequencer step.
// Two-entry queues on the request and result sides let each side stall on its own.
// Synchronous reset empties both queues, puts the sequencer in idle with SCL and SDA
// driven high, and loads phase_ticks 5 and ack_timeout 250.
module i2c_master_byte_engine_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_op,
    input  logic [7:0] i_tx_byte,
    input  logic       i_send_ack,
    input  logic       i_sda_in,
    output logic       empty,
    input  logic       pop,
    output logic       o_scl,
    output logic       o_sda_out,
    output logic       o_sda_oe,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_ack_error,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [0:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    i2cm_pkg::t_cfg    r_cfg;
    i2cm_pkg::t_req    w_req;
    logic              w_take;
    i2cm_pkg::t_result w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks <= i2cm_pkg::PHASE_TICKS_RST;
            r_cfg.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (i2cm_pkg::t_cfg_idx'(i_cfg_index))
                i2cm_pkg::CFG_PHASE_TICKS: r_cfg.phase_ticks <= i_cfg_data;
                i2cm_pkg::CFG_ACK_TIMEOUT: r_cfg.ack_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    i2cm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_op       (i_op),
        .i_tx_byte  (i_tx_byte),
        .i_send_ack (i_send_ack),
        .i_sda_in   (i_sda_in),
        .o_req      (w_req),
        .i_take     (w_take)
    );

    i2cm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (w_req),
        .o_take  (w_take),
        .pop     (pop),
        .empty   (empty),
        .o_res   (w_res)
    );

    assign o_scl       = w_res.scl;
    assign o_sda_out   = w_res.sda_out;
    assign o_sda_oe    = w_res.sda_oe;
    assign o_busy_res  = w_res.busy;
    assign o_done_res  = w_res.done;
    assign o_rx_byte   = w_res.rx_byte;
    assign o_ack_error = w_res.ack_error;

endmodule

### hw/rtl/i2cm_front.sv
// Front end of the I2C master byte engine: takes tick requests, decodes the op
// and holds them in a two-entry queue for the sequencer. Depends on i2cm_pkg.
module i2cm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_op,
    input  logic [7:0]         i_tx_byte,
    input  logic               i_send_ack,
    input  logic               i_sda_in,
    output i2cm_pkg::t_req     o_req,
    input  logic               i_take
);

    i2cm_pkg::t_item                      r_mem [i2cm_pkg::QDepth];
    logic [i2cm_pkg::QPtrW-1:0]           r_wr;
    logic [i2cm_pkg::QPtrW-1:0]           r_rd;
    logic [i2cm_pkg::QCntW-1:0]           r_cnt;
    i2cm_pkg::t_item                      w_item;
    logic                                 w_push;
    logic                                 w_pop;

    always_comb begin
        w_item.tx_byte  = i_tx_byte;
        w_item.send_ack = i_send_ack;
        w_item.sda_in   = i_sda_in;
        unique case (i_op)
            i2cm_pkg::OP_START:    w_item.cmd = i2cm_pkg::CMD_START;
            i2cm_pkg::OP_STOP:     w_item.cmd = i2cm_pkg::CMD_STOP;
            i2cm_pkg::OP_WRITE:    w_item.cmd = i2cm_pkg::CMD_WRITE;
            i2cm_pkg::OP_READ:     w_item.cmd = i2cm_pkg::CMD_READ;
            i2cm_pkg::OP_WAIT_ACK: w_item.cmd = i2cm_pkg::CMD_WAIT_ACK;
            default:               w_item.cmd = i2cm_pkg::CMD_NONE;
        endcase
    end

    assign full        = (r_cnt == i2cm_pkg::QCntW'(i2cm_pkg::QDepth));
    assign w_push      = push && !full;
    assign o_req.valid = (r_cnt != '0);
    assign o_req.item  = r_mem[r_rd];
    assign w_pop       = o_req.valid && i_take;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/i2cm_seq.sv
// Back end of the I2C master byte engine: the bus phase sequencer, advanced one
// tick per request, and the two-entry result queue. Depends on i2cm_pkg.
module i2cm_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  i2cm_pkg::t_cfg     i_cfg,
    input  i2cm_pkg::t_req     i_req,
    output logic               o_take,
    input  logic               pop,
    output logic               empty,
    output i2cm_pkg::t_result  o_res
);

    i2cm_pkg::t_state              r_state, n_state;
    logic [7:0]                    r_phase, n_phase;
    logic [3:0]                    r_bit, n_bit;
    logic [7:0]                    r_shift, n_shift;
    logic [7:0]                    r_wait, n_wait;
    logic                          r_ack, n_ack;
    logic                          r_scl, n_scl;
    logic                          r_sda, n_sda;
    logic                          r_oe, n_oe;
    logic                          r_err, n_err;
    logic [7:0]                    r_rx, n_rx;
    logic                          n_done;

    i2cm_pkg::t_result             r_oq [i2cm_pkg::QDepth];
    logic [i2cm_pkg::QPtrW-1:0]    r_owr;
    logic [i2cm_pkg::QPtrW-1:0]    r_ord;
    logic [i2cm_pkg::QCntW-1:0]    r_ocnt;
    logic                          w_fire;
    logic                          w_pop;
    i2cm_pkg::t_result             w_res;

    always_comb begin
        logic             v_enter;
        i2cm_pkg::t_state v_target;
        logic [7:0]       v_limit;
        i2cm_pkg::t_item  v_it;

        v_it     = i_req.item;
        v_enter  = 1'b0;
        v_target = i2cm_pkg::S_IDLE;
        v_limit  = (i_cfg.phase_ticks == '0) ? 8'd1 : i_cfg.phase_ticks;
        n_state  = r_state;
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_wait   = r_wait;
        n_ack    = r_ack;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_oe     = r_oe;
        n_err    = r_err;
        n_rx     = r_rx;
        n_done   = 1'b0;

        if (r_state == i2cm_pkg::S_IDLE) begin
            unique case (v_it.cmd)
                i2cm_pkg::CMD_START: begin
                    v_enter  = 1'b1;
                    v_target = i2cm_pkg::S_ST_A;
                end
                i2cm_pkg::CMD_STOP: begin
                    v_enter  = 1'b1;
                    v_target = i2cm_pkg::S_SP_A;
                end
                i2cm_pkg::CMD_WRITE: begin
                    n_shift  = v_it.tx_byte;
                    n_bit    = '0;
                    v_enter  = 1'b1;
                    v_target = i2cm_pkg::S_WR_LO;
                end
                i2cm_pkg::CMD_READ: begin
                    n_shift  = '0;
                    n_bit    = '0;
                    n_ack    = v_it.send_ack;
                    v_enter  = 1'b1;
                    v_target = i2cm_pkg::S_RD_LO;
                end
                i2cm_pkg::CMD_WAIT_ACK: begin
                    n_err    = 1'b0;
                    v_enter  = 1'b1;
                    v_target = i2cm_pkg::S_WA_LO;
                end
                default: begin
                end
            endcase
        end else if (r_state == i2cm_pkg::S_WA_POLL) begin
            if (!v_it.sda_in) begin
                n_scl   = 1'b0;
                n_state = i2cm_pkg::S_IDLE;
                n_phase = '0;
                n_done  = 1'b1;
            end else if (r_wait >= i_cfg.ack_timeout) begin
                n_err    = 1'b1;
                v_enter  = 1'b1;
                v_target = i2cm_pkg::S_SP_A;
            end else begin
                n_wait = r_wait + 8'd1;
            end
        end else if (r_phase < v_limit) begin
            n_phase = r_phase + 8'd1;
        end else begin
            unique case (r_state)
                i2cm_pkg::S_ST_A: begin
                    v_enter  = 1'b1;
                    v_target = i2cm_pkg::S_ST_B;
                end
                i2cm_pkg::S_ST_B: begin
                    v_enter  = 1'b1;
                    v_target = i2cm_pkg::S_ST_C;
                end
                i2cm_pkg::S_SP_A: begin
                    v_enter  = 1'b1;
                    v_target = i2cm_pkg::S_SP_B;
                end
                i2cm_pkg::S_SP_B: begin
                    v_enter  = 1'b1;
                    v_target = i2cm_pkg::S_SP_C;
                end
                i2cm_pkg::S_ST_C, i2cm_pkg::S_SP_C: begin
                    n_state = i2cm_pkg::S_IDLE;
                    n_phase = '0;
                    n_done  = 1'b1;
                end
                i2cm_pkg::S_WR_LO: begin
                    v_enter  = 1'b1;
                    v_target = i2cm_pkg::S_WR_HI;
                end
                i2cm_pkg::S_WR_HI: begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit   = r_bit + 4'd1;
                    if (n_bit >= i2cm_pkg::BITS_PER_BYTE) begin
                        n_scl   = 1'b0;
                        n_state = i2cm_pkg::S_IDLE;
                        n_phase = '0;
                        n_done  = 1'b1;
                    end else begin
                        v_enter  = 1'b1;
                        v_target = i2cm_pkg::S_WR_LO;
                    end
                end
                i2cm_pkg::S_RD_LO: begin
                    v_enter  = 1'b1;
                    v_target = i2cm_pkg::S_RD_HI;
                end
                i2cm_pkg::S_RD_HI: begin
                    n_shift = {r_shift[6:0], v_it.sda_in};
                    n_bit   = r_bit + 4'd1;
                    v_enter = 1'b1;
                    if (n_bit >= i2cm_pkg::BITS_PER_BYTE) begin
                        n_rx     = n_shift;
                        v_target = i2cm_pkg::S_AK_LO;
                    end else begin
                        v_target = i2cm_pkg::S_RD_LO;
                    end
                end
                i2cm_pkg::S_AK_LO: begin
                    v_enter  = 1'b1;
                    v_target = i2cm_pkg::S_AK_HI;
                end
                i2cm_pkg::S_AK_HI: begin
                    n_scl   = 1'b0;
                    n_state = i2cm_pkg::S_IDLE;
                    n_phase = '0;
                    n_done  = 1'b1;
                end
                i2cm_pkg::S_WA_LO: begin
                    v_enter  = 1'b1;
                    v_target = i2cm_pkg::S_WA_POLL;
                end
                default: begin
                    n_state = i2cm_pkg::S_IDLE;
                end
            endcase
        end

        if (v_enter) begin
            n_state = v_target;
            n_phase = 8'd1;
            unique case (v_target)
                i2cm_pkg::S_ST_A, i2cm_pkg::S_SP_C: begin
                    {n_scl, n_sda, n_oe} = 3'b111;
                end
                i2cm_pkg::S_ST_B, i2cm_pkg::S_SP_B: begin
                    {n_scl, n_sda, n_oe} = 3'b101;
                end
                i2cm_pkg::S_ST_C, i2cm_pkg::S_SP_A: begin
                    {n_scl, n_sda, n_oe} = 3'b001;
                end
                i2cm_pkg::S_WR_LO: begin
                    {n_scl, n_sda, n_oe} = {1'b0, n_shift[7], 1'b1};
                end
                i2cm_pkg::S_WR_HI: begin
                    {n_scl, n_sda, n_oe} = {1'b1, n_shift[7], 1'b1};
                end
                i2cm_pkg::S_RD_LO, i2cm_pkg::S_WA_LO: begin
                    {n_scl, n_sda, n_oe} = 3'b010;
                end
                i2cm_pkg::S_RD_HI: begin
                    {n_scl, n_sda, n_oe} = 3'b110;
                end
                i2cm_pkg::S_AK_LO: begin
                    {n_scl, n_sda, n_oe} = {1'b0, ~n_ack, 1'b1};
                end
                i2cm_pkg::S_AK_HI: begin
                    {n_scl, n_sda, n_oe} = {1'b1, ~n_ack, 1'b1};
                end
                i2cm_pkg::S_WA_POLL: begin
                    {n_scl, n_sda, n_oe} = 3'b110;
                    n_wait = '0;
                end
                default: begin
                    n_state = i2cm_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign w_res.scl       = n_scl;
    assign w_res.sda_out   = n_sda;
    assign w_res.sda_oe    = n_oe;
    assign w_res.busy      = (n_state != i2cm_pkg::S_IDLE);
    assign w_res.done      = n_done;
    assign w_res.rx_byte   = n_rx;
    assign w_res.ack_error = n_err;

    assign w_fire = i_req.valid && (r_ocnt != i2cm_pkg::QCntW'(i2cm_pkg::QDepth));
    assign o_take = w_fire;
    assign empty  = (r_ocnt == '0);
    assign o_res  = r_oq[r_ord];
    assign w_pop  = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2cm_pkg::S_IDLE;
            r_phase <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_wait  <= '0;
            r_ack   <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_oe    <= 1'b1;
            r_err   <= 1'b0;
            r_rx    <= '0;
        end else if (w_fire) begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_wait  <= n_wait;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_oe    <= n_oe;
            r_err   <= n_err;
            r_rx    <= n_rx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_oq[r_owr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
        end else begin
            if (w_fire) begin
                r_owr <= r_owr + 1'b1;
            end
            if (w_pop) begin
                r_ord <= r_ord + 1'b1;
            end
            if (w_fire && !w_pop) begin
                r_ocnt <= r_ocnt + 1'b1;
            end else if (!w_fire && w_pop) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

`include "i2c_master_byte_engine_top_assert.svh"

    `I2CM_ASSERT_HOLD(a_state_onehot, $onehot(r_state), "Sequencer state is not one-hot.")
    `I2CM_ASSERT_HOLD(a_ocnt_bound, r_ocnt <= i2cm_pkg::QCntW'(i2cm_pkg::QDepth), "Result queue overflow.")
    `I2CM_ASSERT_HOLD(a_phase_live, (r_state == i2cm_pkg::S_IDLE) || (r_state == i2cm_pkg::S_WA_POLL) || (r_phase != '0), "Active phase has a zero count.")
    `I2CM_ASSERT_NEXT(a_none_idle, w_fire && (r_state == i2cm_pkg::S_IDLE) && (i_req.item.cmd == i2cm_pkg::CMD_NONE), r_state == i2cm_pkg::S_IDLE, "Empty request left idle.")

endmodule

### tb/testbench.sv
// Self-checking testbench for the I2C master byte engine: bus ticks and commands go in
// as requests, and every result is compared with a cycle-true predictor of the sequencer.
// Depends on i2cm_pkg and i2c_master_byte_engine_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;
    localparam int ACK_NEVER    = 100000;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx;
        logic       ack;
        logic       sda;
    } t_tick;

    typedef struct packed {
        i2cm_pkg::t_state st;
        logic [7:0] phase_cnt;
        logic [3:0] bits;
        logic [7:0] shreg;
        logic [7:0] wait_cnt;
        logic       ack_sel;
        logic       scl;
        logic       sda;
        logic       oe;
        logic       err;
        logic [7:0] rx;
        logic       done;
    } t_bus;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [2:0] i_op = '0;
    logic [7:0] i_tx_byte = '0;
    logic       i_send_ack = 1'b0;
    logic       i_sda_in = 1'b1;
    logic       empty;
    logic       pop = 1'b0;
    logic       o_scl;
    logic       o_sda_out;
    logic       o_sda_oe;
    logic       o_busy_res;
    logic       o_done_res;
    logic [7:0] o_rx_byte;
    logic       o_ack_error;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [0:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    t_tick   tick_q[$];
    i2cm_pkg::t_result line_expect_q[$];
    t_bus    chk_bus;
    t_bus    gen_bus;
    logic [7:0] phase_len;
    logic [7:0] ack_limit;
    int      n_errors = 0;
    int      cycle_cnt = 0;
    int      gen_ticks = 0;
    logic [7:0] rx_pat;
    int      ack_plan;
    int      poll_ticks;
    int      burst_left = 0;
    int      gap_left = 0;
    int      pop_mode = 0;
    int      mode_left = 0;
    int      stall_left = 0;
    logic [1:0] pop_phase = '0;

    i2c_master_byte_engine_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_op(i_op),
        .i_tx_byte(i_tx_byte),
        .i_send_ack(i_send_ack),
        .i_sda_in(i_sda_in),
        .empty(empty),
        .pop(pop),
        .o_scl(o_scl),
        .o_sda_out(o_sda_out),
        .o_sda_oe(o_sda_oe),
        .o_busy_res(o_busy_res),
        .o_done_res(o_done_res),
        .o_rx_byte(o_rx_byte),
        .o_ack_error(o_ack_error),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_bus bus_reset();
        t_bus b;
        b = '0;
        b.st = i2cm_pkg::S_IDLE;
        b.scl = 1'b1;
        b.sda = 1'b1;
        b.oe = 1'b1;
        return b;
    endfunction

    function automatic t_bus bus_enter(t_bus b, i2cm_pkg::t_state s);
        logic dbit;
        logic abit;
        dbit = b.shreg[7];
        abit = ~b.ack_sel;
        b.st = s;
        b.phase_cnt = 8'd1;
        case (s)
            i2cm_pkg::S_ST_A:    {b.scl, b.sda, b.oe} = 3'b111;
            i2cm_pkg::S_ST_B:    {b.scl, b.sda, b.oe} = 3'b101;
            i2cm_pkg::S_ST_C:    {b.scl, b.sda, b.oe} = 3'b001;
            i2cm_pkg::S_SP_A:    {b.scl, b.sda, b.oe} = 3'b001;
            i2cm_pkg::S_SP_B:    {b.scl, b.sda, b.oe} = 3'b101;
            i2cm_pkg::S_SP_C:    {b.scl, b.sda, b.oe} = 3'b111;
            i2cm_pkg::S_WR_LO:   {b.scl, b.sda, b.oe} = {1'b0, dbit, 1'b1};
            i2cm_pkg::S_WR_HI:   {b.scl, b.sda, b.oe} = {1'b1, dbit, 1'b1};
            i2cm_pkg::S_RD_LO:   {b.scl, b.sda, b.oe} = 3'b010;
            i2cm_pkg::S_RD_HI:   {b.scl, b.sda, b.oe} = 3'b110;
            i2cm_pkg::S_AK_LO:   {b.scl, b.sda, b.oe} = {1'b0, abit, 1'b1};
            i2cm_pkg::S_AK_HI:   {b.scl, b.sda, b.oe} = {1'b1, abit, 1'b1};
            i2cm_pkg::S_WA_LO:   {b.scl, b.sda, b.oe} = 3'b010;
            i2cm_pkg::S_WA_POLL: begin
                {b.scl, b.sda, b.oe} = 3'b110;
                b.wait_cnt = '0;
            end
            default:   b.st = i2cm_pkg::S_IDLE;
        endcase
        return b;
    endfunction

    function automatic t_bus bus_finish(t_bus b);
        b.st = i2cm_pkg::S_IDLE;
        b.phase_cnt = '0;
        b.done = 1'b1;
        return b;
    endfunction

    function automatic t_bus bus_phase_end(t_bus b, logic sda);
        case (b.st)
            i2cm_pkg::S_ST_A:  b = bus_enter(b, i2cm_pkg::S_ST_B);
            i2cm_pkg::S_ST_B:  b = bus_enter(b, i2cm_pkg::S_ST_C);
            i2cm_pkg::S_ST_C:  b = bus_finish(b);
            i2cm_pkg::S_SP_A:  b = bus_enter(b, i2cm_pkg::S_SP_B);
            i2cm_pkg::S_SP_B:  b = bus_enter(b, i2cm_pkg::S_SP_C);
            i2cm_pkg::S_SP_C:  b = bus_finish(b);
            i2cm_pkg::S_WR_LO: b = bus_enter(b, i2cm_pkg::S_WR_HI);
            i2cm_pkg::S_WR_HI: begin
                b.shreg = {b.shreg[6:0], 1'b0};
                b.bits = b.bits + 4'd1;
                if (b.bits >= i2cm_pkg::BITS_PER_BYTE) begin
                    b.scl = 1'b0;
                    b = bus_finish(b);
                end else begin
                    b = bus_enter(b, i2cm_pkg::S_WR_LO);
                end
            end
            i2cm_pkg::S_RD_LO: b = bus_enter(b, i2cm_pkg::S_RD_HI);
            i2cm_pkg::S_RD_HI: begin
                b.shreg = {b.shreg[6:0], sda};
                b.bits = b.bits + 4'd1;
                if (b.bits >= i2cm_pkg::BITS_PER_BYTE) begin
                    b.rx = b.shreg;
                    b = bus_enter(b, i2cm_pkg::S_AK_LO);
                end else begin
                    b = bus_enter(b, i2cm_pkg::S_RD_LO);
                end
            end
            i2cm_pkg::S_AK_LO: b = bus_enter(b, i2cm_pkg::S_AK_HI);
            i2cm_pkg::S_AK_HI: begin
                b.scl = 1'b0;
                b = bus_finish(b);
            end
            i2cm_pkg::S_WA_LO: b = bus_enter(b, i2cm_pkg::S_WA_POLL);
            default: b.st = i2cm_pkg::S_IDLE;
        endcase
        return b;
    endfunction

    function automatic t_bus bus_tick(t_bus b, t_tick t, logic [7:0] plen, logic [7:0] tmo);
        logic [7:0] lim;
        b.done = 1'b0;
        lim = (plen == 8'd0) ? 8'd1 : plen;
        if (b.st == i2cm_pkg::S_IDLE) begin
            case (t.op)
                i2cm_pkg::CMD_START:    b = bus_enter(b, i2cm_pkg::S_ST_A);
                i2cm_pkg::CMD_STOP:     b = bus_enter(b, i2cm_pkg::S_SP_A);
                i2cm_pkg::CMD_WRITE: begin
                    b.shreg = t.tx;
                    b.bits = '0;
                    b = bus_enter(b, i2cm_pkg::S_WR_LO);
                end
                i2cm_pkg::CMD_READ: begin
                    b.shreg = '0;
                    b.bits = '0;
                    b.ack_sel = t.ack;
                    b = bus_enter(b, i2cm_pkg::S_RD_LO);
                end
                i2cm_pkg::CMD_WAIT_ACK: begin
                    b.err = 1'b0;
                    b = bus_enter(b, i2cm_pkg::S_WA_LO);
                end
                default: begin
                end
            endcase
        end else if (b.st == i2cm_pkg::S_WA_POLL) begin
            if (!t.sda) begin
                b.scl = 1'b0;
                b = bus_finish(b);
            end else if (b.wait_cnt >= tmo) begin
                b.err = 1'b1;
                b = bus_enter(b, i2cm_pkg::S_SP_A);
            end else begin
                b.wait_cnt = b.wait_cnt + 8'd1;
            end
        end else if (b.phase_cnt < lim) begin
            b.phase_cnt = b.phase_cnt + 8'd1;
        end else begin
            b = bus_phase_end(b, t.sda);
        end
        return b;
    endfunction

    function automatic i2cm_pkg::t_result bus_view(t_bus b);
        i2cm_pkg::t_result r;
        r.scl = b.scl;
        r.sda_out = b.sda;
        r.sda_oe = b.oe;
        r.busy = (b.st != i2cm_pkg::S_IDLE);
        r.done = b.done;
        r.rx_byte = b.rx;
        r.ack_error = b.err;
        return r;
    endfunction

    function automatic void match_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            n_errors++;
        end
    endfunction

    function automatic int pick_plan();
        int p;
        case ($urandom_range(6, 0))
            4:       p = int'(ack_limit) - 1;
            5:       p = int'(ack_limit);
            6:       p = int'(ack_limit) + 1;
            default: p = $urandom_range(3, 0);
        endcase
        return p;
    endfunction

    // The stimulus side keeps its own copy of the engine so that it knows when the
    // bus is idle and which SDA level each tick should present.
    task automatic gen_tick(input logic [2:0] op, input logic [7:0] tx, input logic ack);
        t_tick t;
        t.op = op;
        t.tx = tx;
        t.ack = ack;
        t.sda = 1'($urandom);
        if (gen_bus.st == i2cm_pkg::S_WA_POLL) begin
            t.sda = (poll_ticks < ack_plan);
            poll_ticks++;
        end else if (gen_bus.st == i2cm_pkg::S_RD_HI) begin
            t.sda = rx_pat[3'd7 - gen_bus.bits[2:0]];
        end
        gen_bus = bus_tick(gen_bus, t, phase_len, ack_limit);
        tick_q.push_back(t);
        gen_ticks++;
    endtask

    task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                           input logic [7:0] pat, input int plan);
        logic [2:0] stray;
        rx_pat = pat;
        ack_plan = plan;
        poll_ticks = 0;
        gen_tick(op, tx, ack);
        while (gen_bus.st != i2cm_pkg::S_IDLE) begin
            stray = ($urandom_range(9, 0) == 0) ? 3'($urandom) : i2cm_pkg::CMD_NONE;
            gen_tick(stray, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_transaction();
        int n;
        run_cmd(i2cm_pkg::CMD_START, 8'($urandom), 1'($urandom), 8'($urandom), 0);
        run_cmd(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom), 8'($urandom), 0);
        run_cmd(i2cm_pkg::CMD_WAIT_ACK, 8'($urandom), 1'($urandom), 8'($urandom),
                pick_plan());
        n = $urandom_range(3, 0);
        repeat (n) begin
            if ($urandom_range(1, 0) == 0) begin
                run_cmd(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom), 8'($urandom), 0);
                run_cmd(i2cm_pkg::CMD_WAIT_ACK, 8'($urandom), 1'($urandom), 8'($urandom),
                        pick_plan());
            end else begin
                run_cmd(i2cm_pkg::CMD_READ, 8'($urandom), 1'($urandom), 8'($urandom), 0);
            end
        end
        run_cmd(i2cm_pkg::CMD_STOP, 8'($urandom), 1'($urandom), 8'($urandom), 0);
    endtask

    task automatic run_random(input int n, input bit full_txn);
        int t0;
        int r;
        logic [2:0] op;
        t0 = gen_ticks;
        while (gen_ticks - t0 < n) begin
            r = $urandom_range(99, 0);
            if (full_txn && r < 65) begin
                run_transaction();
            end else if (r < 88) begin
                case ($urandom_range(6, 0))
                    0:       op = i2cm_pkg::CMD_START;
                    1:       op = i2cm_pkg::CMD_STOP;
                    2:       op = i2cm_pkg::CMD_WRITE;
                    3:       op = i2cm_pkg::CMD_READ;
                    4:       op = i2cm_pkg::CMD_WAIT_ACK;
                    5:       op = OP_RSVD6;
                    default: op = OP_RSVD7;
                endcase
                if (!full_txn && (op == i2cm_pkg::CMD_WRITE || op == i2cm_pkg::CMD_READ)) begin
                    op = i2cm_pkg::CMD_WAIT_ACK;
                end
                run_cmd(op, 8'($urandom), 1'($urandom), 8'($urandom), pick_plan());
            end else begin
                repeat ($urandom_range(3, 1)) begin
                    gen_tick(i2cm_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
                end
            end
        end
    endtask

    task automatic drain();
        while (tick_q.size() > 0 || line_expect_q.size() > 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [7:0] plen, input logic [7:0] tmo);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= i2cm_pkg::CFG_PHASE_TICKS;
        i_cfg_data <= plen;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= i2cm_pkg::CFG_ACK_TIMEOUT;
        i_cfg_data <= tmo;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        phase_len = plen;
        ack_limit = tmo;
    endtask

    task automatic run_phase(input logic [7:0] plen, input logic [7:0] tmo, input int n,
                             input bit full_txn);
        cfg_write(plen, tmo);
        run_random(n, full_txn);
        drain();
    endtask

    always @(posedge i_clk) begin
        logic go;
        if (!i_rst_n) begin
            chk_bus = bus_reset();
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                chk_bus = bus_tick(chk_bus, tick_q.pop_front(), phase_len, ack_limit);
                line_expect_q.push_back(bus_view(chk_bus));
                if (burst_left > 0) burst_left--;
            end
            go = 1'b0;
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(200, 50)
                                                         : $urandom_range(30, 1);
                gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
            end
            if (burst_left > 0) begin
                go = (tick_q.size() > 0);
            end else begin
                gap_left--;
            end
            push <= go;
            if (go) begin
                i_op <= tick_q[0].op;
                i_tx_byte <= tick_q[0].tx;
                i_send_ack <= tick_q[0].ack;
                i_sda_in <= tick_q[0].sda;
            end
        end
    end

    always @(posedge i_clk) begin
        i2cm_pkg::t_result want;
        i2cm_pkg::t_result got;
        logic nxt_pop;
        if (i_rst_n && pop && !empty) begin
            got.scl = o_scl;
            got.sda_out = o_sda_out;
            got.sda_oe = o_sda_oe;
            got.busy = o_busy_res;
            got.done = o_done_res;
            got.rx_byte = o_rx_byte;
            got.ack_error = o_ack_error;
            if (line_expect_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0h", $time, got);
                n_errors++;
            end else begin
                want = line_expect_q.pop_front();
                match_field("scl", 8'(want.scl), 8'(got.scl));
                match_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
                match_field("sda_oe", 8'(want.sda_oe), 8'(got.sda_oe));
                match_field("busy", 8'(want.busy), 8'(got.busy));
                match_field("done", 8'(want.done), 8'(got.done));
                match_field("rx_byte", want.rx_byte, got.rx_byte);
                match_field("ack_error", 8'(want.ack_error), 8'(got.ack_error));
            end
        end
        if (mode_left == 0) begin
            pop_mode = $urandom_range(3, 0);
            mode_left = $urandom_range(200, 50);
        end else begin
            mode_left--;
        end
        pop_phase <= pop_phase + 2'd1;
        case (pop_mode)
            0:       nxt_pop = 1'b1;
            1:       nxt_pop = 1'($urandom);
            2:       nxt_pop = (pop_phase == 2'd0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    nxt_pop = 1'b0;
                end else begin
                    stall_left = $urandom_range(12, 1);
                    nxt_pop = 1'b1;
                end
            end
        endcase
        pop <= nxt_pop;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        gen_bus = bus_reset();
        phase_len = i2cm_pkg::PHASE_TICKS_RST;
        ack_limit = i2cm_pkg::ACK_TIMEOUT_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset timing: a start, then a wait for acknowledge that never comes, so the
        // engine times out and issues its own stop; unknown codes act as no command.
        run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(i2cm_pkg::CMD_WAIT_ACK, 8'hFF, 1'b1, 8'h00, ACK_NEVER);
        gen_tick(OP_RSVD6, 8'hFF, 1'b1);
        gen_tick(OP_RSVD7, 8'h00, 1'b0);
        drain();

        // Zero phase length behaves as one tick; a zero timeout fails on the first
        // high sample.
        cfg_write(8'd0, 8'd0);
        run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1, 8'h00, 0);
        run_cmd(i2cm_pkg::CMD_WRITE, 8'h00, 1'b0, 8'hFF, 0);
        run_cmd(i2cm_pkg::CMD_READ, 8'h00, 1'b1, 8'hFF, 0);
        run_cmd(i2cm_pkg::CMD_READ, 8'hFF, 1'b0, 8'h00, 0);
        run_cmd(i2cm_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(i2cm_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 8'h00, ACK_NEVER);
        run_cmd(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 8'h00, 0);
        gen_tick(i2cm_pkg::CMD_NONE, 8'h00, 1'b0);
        drain();

        run_phase(8'd1, 8'd1, 20, 1'b1);
        run_phase(8'd2, 8'd7, 1, 1'b1);
        run_phase(8'd3, 8'($urandom_range(20, 1)), 20, 1'b0);
        run_phase(8'd1, 8'd255, 1, 1'b1);
        run_phase(8'($urandom_range(3, 1)), 8'($urandom_range(12, 1)), 1, 1'b1);
        run_phase(8'd16, 8'd1, 40, 1'b0);
        run_phase(8'd2, 8'd0, 1, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
